[sv/bcd_adj_pkg.sv]
// Shared types, operation codes and constants for the x86 BCD adjust unit.
// Used by bcd_adj_front, bcd_adj_cell and x86_bcd_adjust_unit_top.
`timescale 1ns / 1ps
`default_nettype none

package bcd_adj_pkg;

    // Operation codes carried in req_type
    typedef enum logic [2:0] {
        OP_AAA = 3'd0,
        OP_AAS = 3'd1,
        OP_DAA = 3'd2,
        OP_DAS = 3'd3,
        OP_AAM = 3'd4,
        OP_AAD = 3'd5
    } t_op;

    // One quotient bit per cell, one cell per bit of AL
    localparam int C_NCELL = 8;

    localparam logic [3:0]  C_DIGIT_MAX = 4'h9;
    localparam logic [15:0] C_ASCII_ADJ = 16'h0106;
    localparam logic [15:0] C_ASCII_MSK = 16'hff0f;
    localparam logic [7:0]  C_LO_ADJ    = 8'h06;
    localparam logic [7:0]  C_HI_ADJ    = 8'h60;
    localparam logic [7:0]  C_BCD_MAX   = 8'h99;
    localparam logic [7:0]  C_DAA_CARRY = 8'hff - 8'h06;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] ax_in;
        logic        af_in;
        logic        cf_in;
        logic [7:0]  base;
    } t_req;

    typedef struct packed {
        logic [15:0] ax_out;
        logic        cf_out;
        logic        af_out;
        logic        zf_out;
        logic        sf_out;
        logic        pf_out;
        logic        divide_error;
    } t_rsp;

    // Data handed from cell to cell down the chain
    typedef struct packed {
        logic        vld;   // slot holds an instruction
        logic        div;   // AAM with a nonzero base: take quotient/remainder
        logic [7:0]  rem;   // partial remainder
        logic [7:0]  dq;    // dividend bits shifting out, quotient bits in
        logic [7:0]  dvsr;  // divisor
        t_rsp        rsp;   // result for every other case
    } t_cell;

    function automatic logic even_par8(input logic [7:0] v);
        even_par8 = ~(^v);
    endfunction

endpackage

`default_nettype wire

[sv/bcd_adj_front.sv]
// Entry of the chain: decodes one instruction and computes every result
// except the AAM quotient/remainder. Depends on bcd_adj_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bcd_adj_front (
    input  wire logic              i_valid,
    input  wire bcd_adj_pkg::t_req i_req,
    output bcd_adj_pkg::t_cell     o_cell
);

    logic [7:0]  al;
    logic [7:0]  ah;
    logic        lo_adj;
    logic        hi_adj;
    logic [15:0] prod16;
    logic [7:0]  prod;
    logic [8:0]  sum;
    logic [4:0]  nib_sum;
    logic [7:0]  adj_al;
    logic        adj_cf;

    always_comb begin
        al      = i_req.ax_in[7:0];
        ah      = i_req.ax_in[15:8];
        lo_adj  = (al[3:0] > bcd_adj_pkg::C_DIGIT_MAX) || i_req.af_in;
        hi_adj  = (al > bcd_adj_pkg::C_BCD_MAX) || i_req.cf_in;
        prod16  = {8'h00, ah} * {8'h00, i_req.base};
        prod    = prod16[7:0];
        sum     = {1'b0, al} + {1'b0, prod};
        nib_sum = {1'b0, al[3:0]} + {1'b0, prod[3:0]};
        adj_al  = al;
        adj_cf  = 1'b0;

        // default: pass everything through
        o_cell                  = '0;
        o_cell.vld              = i_valid;
        o_cell.dq               = al;
        o_cell.dvsr             = i_req.base;
        o_cell.rsp.ax_out       = i_req.ax_in;
        o_cell.rsp.cf_out       = i_req.cf_in;
        o_cell.rsp.af_out       = i_req.af_in;

        case (bcd_adj_pkg::t_op'(i_req.req_type))
            bcd_adj_pkg::OP_AAA: begin
                o_cell.rsp.ax_out = (lo_adj ? i_req.ax_in + bcd_adj_pkg::C_ASCII_ADJ
                                            : i_req.ax_in) & bcd_adj_pkg::C_ASCII_MSK;
                o_cell.rsp.cf_out = lo_adj;
                o_cell.rsp.af_out = lo_adj;
            end
            bcd_adj_pkg::OP_AAS: begin
                o_cell.rsp.ax_out = (lo_adj ? i_req.ax_in - bcd_adj_pkg::C_ASCII_ADJ
                                            : i_req.ax_in) & bcd_adj_pkg::C_ASCII_MSK;
                o_cell.rsp.cf_out = lo_adj;
                o_cell.rsp.af_out = lo_adj;
            end
            bcd_adj_pkg::OP_DAA: begin
                if (lo_adj) begin
                    adj_cf = i_req.cf_in || (al > bcd_adj_pkg::C_DAA_CARRY);
                    adj_al = al + bcd_adj_pkg::C_LO_ADJ;
                end
                if (hi_adj) begin
                    adj_al = adj_al + bcd_adj_pkg::C_HI_ADJ;
                    adj_cf = 1'b1;
                end
                o_cell.rsp.ax_out = {ah, adj_al};
                o_cell.rsp.cf_out = adj_cf;
                o_cell.rsp.af_out = lo_adj;
            end
            bcd_adj_pkg::OP_DAS: begin
                if (lo_adj) begin
                    adj_cf = i_req.cf_in || (al < bcd_adj_pkg::C_LO_ADJ);
                    adj_al = al - bcd_adj_pkg::C_LO_ADJ;
                end
                if (hi_adj) begin
                    adj_al = adj_al - bcd_adj_pkg::C_HI_ADJ;
                    adj_cf = 1'b1;
                end
                o_cell.rsp.ax_out = {ah, adj_al};
                o_cell.rsp.cf_out = adj_cf;
                o_cell.rsp.af_out = lo_adj;
            end
            bcd_adj_pkg::OP_AAM: begin
                // base zero traps; AX and flags pass through
                if (i_req.base == 8'h00) begin
                    o_cell.rsp.divide_error = 1'b1;
                end else begin
                    o_cell.div = 1'b1;
                end
            end
            bcd_adj_pkg::OP_AAD: begin
                o_cell.rsp.ax_out = {8'h00, sum[7:0]};
                o_cell.rsp.cf_out = sum[8];
                o_cell.rsp.af_out = nib_sum[4];
            end
            default: begin
                // undefined codes act as no operation
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/bcd_adj_cell.sv]
// One restoring-division step: shifts in one dividend bit, produces one
// quotient bit, and registers the slot for the next cell. Depends on bcd_adj_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bcd_adj_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire bcd_adj_pkg::t_cell i_cell,
    output bcd_adj_pkg::t_cell      o_cell
);

    bcd_adj_pkg::t_cell r_cell;
    bcd_adj_pkg::t_cell n_cell;
    logic [8:0] rem_sh;
    logic [8:0] diff;
    logic       qbit;

    always_comb begin
        rem_sh = {i_cell.rem, i_cell.dq[7]};
        diff   = rem_sh - {1'b0, i_cell.dvsr};
        qbit   = (rem_sh >= {1'b0, i_cell.dvsr});
        n_cell = i_cell;
        n_cell.rem = qbit ? diff[7:0] : rem_sh[7:0];
        n_cell.dq  = {i_cell.dq[6:0], qbit};
    end

    // valid needs reset, the payload does not
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.vld <= 1'b0;
        end else begin
            r_cell.vld <= n_cell.vld;
        end
        r_cell.div  <= n_cell.div;
        r_cell.rem  <= n_cell.rem;
        r_cell.dq   <= n_cell.dq;
        r_cell.dvsr <= n_cell.dvsr;
        r_cell.rsp  <= n_cell.rsp;
    end

    assign o_cell = r_cell;

endmodule

`default_nettype wire

[sv/x86_bcd_adjust_unit_top.sv]
// Top level of the x86 BCD adjust unit (AAA, AAS, DAA, DAS, AAM, AAD).
// Depends on bcd_adj_pkg, bcd_adj_front and bcd_adj_cell.
// A transfer passes through the division cells, then the output register, to o_strobe.
// Throughput: one instruction per cycle while busy is low; AAM divides through a chain of
// 8 division cells, one quotient bit each, and every opcode rides the same chain.
// Reset: synchronous, active low; clears the chain valids and o_strobe, holds busy high.
`timescale 1ns / 1ps
`default_nettype none

module x86_bcd_adjust_unit_top (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire bcd_adj_pkg::t_req i_req,
    output logic                   o_strobe,
    output bcd_adj_pkg::t_rsp      o_rsp
);

    localparam int NCELL = bcd_adj_pkg::C_NCELL;

    // Slot entering each cell; the last entry is the chain's output
    bcd_adj_pkg::t_cell w_chain [0:NCELL];

    logic              r_busy;
    logic              r_strobe;
    bcd_adj_pkg::t_rsp r_rsp;
    bcd_adj_pkg::t_rsp n_rsp;
    logic              w_accept;

    // Take a transfer whenever start is high and busy is low; the receiver cannot stall
    assign w_accept = start && !r_busy;

    bcd_adj_front u_front (
        .i_valid (w_accept),
        .i_req   (i_req),
        .o_cell  (w_chain[0])
    );

    // Advance every slot one cell per clock
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        bcd_adj_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cell  (w_chain[g]),
            .o_cell  (w_chain[g+1])
        );
    end

    // Merge the AAM quotient/remainder, then derive ZF, SF, PF from final AL
    always_comb begin
        n_rsp = w_chain[NCELL].rsp;
        if (w_chain[NCELL].div) begin
            n_rsp.ax_out = {w_chain[NCELL].dq, w_chain[NCELL].rem};
        end
        n_rsp.zf_out = (n_rsp.ax_out[7:0] == 8'h00);
        n_rsp.sf_out = n_rsp.ax_out[7];
        n_rsp.pf_out = bcd_adj_pkg::even_par8(n_rsp.ax_out[7:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_strobe <= 1'b0;
        end else begin
            r_busy   <= 1'b0;
            r_strobe <= w_chain[NCELL].vld;
        end
    end

    // Hold the result register without reset
    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign busy     = r_busy;
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

    // Busy must cover the cycle after any reset cycle
    a_busy_after_rst: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("busy low right after reset");

    // Every accepted transfer comes out as an o_strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##9 o_strobe)
        else $error("result strobe missing after transfer");

    // A finished division leaves a remainder below the divisor
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_chain[NCELL].vld && w_chain[NCELL].div) |->
        (w_chain[NCELL].rem < w_chain[NCELL].dvsr))
        else $error("AAM remainder not below base");

    // A divide error is never raised together with a division result
    a_div_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_chain[NCELL].vld && w_chain[NCELL].rsp.divide_error) |->
        !w_chain[NCELL].div)
        else $error("divide error on a dividing slot");

endmodule

`default_nettype wire
